### sv/bgd_pkg.sv
// bgd_pkg: shared types, constants and helpers for the button gesture detector.
// No dependencies; used by bgd_core, bgd_evq and button_gesture_detector_top.
`timescale 1ns / 1ps

package bgd_pkg;

   // Width of the hold and click-window timers.
   localparam int TIME_WIDTH = 16;
   localparam int IDX_WIDTH  = 2;

   localparam logic [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1);

   // Configuration register indexes.
   localparam logic [IDX_WIDTH-1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [IDX_WIDTH-1:0] CSR_CLICK_WINDOW = 2'd1;
   localparam logic [IDX_WIDTH-1:0] CSR_DEBOUNCE     = 2'd2;

   localparam logic [15:0] LONG_PRESS_RESET   = 16'd2000;
   localparam logic [15:0] CLICK_WINDOW_RESET = 16'd300;
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd30;

   typedef enum logic [2:0] {
      EV_PRESSED  = 3'd0,
      EV_RELEASED = 3'd1,
      EV_LONG     = 3'd2,
      EV_CLICK    = 3'd3,
      EV_DOUBLE   = 3'd4,
      EV_TRIPLE   = 3'd5
   } evt_type;

   typedef struct packed {
      logic [15:0] long_press_ms;
      logic [15:0] click_window_ms;
      logic [7:0]  debounce_ms;
   } cfg_type;

   // Events caused by one tick, in emission order.
   typedef struct packed {
      logic [1:0] count;
      evt_type    code2;
      evt_type    code1;
      evt_type    code0;
   } evgrp_type;

   // Register value cut (or zero-extended) to the timer width.
   function automatic logic [TIME_WIDTH-1:0] to_time(input logic [15:0] v);
      logic [TIME_WIDTH-1:0] r;
      r = '0;
      for (int i = 0; i < TIME_WIDTH; i++) begin
         if (i < 16) begin
            r[i] = v[i];
         end
      end
      return r;
   endfunction

endpackage

### sv/button_gesture_detector_top.sv
// button_gesture_detector_top: debounced button gesture detector, top level.
// Depends on bgd_pkg, bgd_core and bgd_evq.
// Path: a tick transfer is registered, evaluated once the event queue can take its
//   group, and its first event is offered on rsp from the event group register.
// Throughput: one tick per cycle when it causes no event; a tick causing k events
//   (k up to 3) holds the event group register until all k are sent, one per rsp transfer.
// Reset: synchronous, active high; clears all gesture state and loads the
//   register defaults (long press 2000, click window 300, debounce 30).
`timescale 1ns / 1ps

module button_gesture_detector_top (
   input  logic        clock,
   input  logic        reset,
   // tick channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pin_level, [7:1] zero
   // event channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] event_code, [7:3] zero
   output logic        rsp_tlast,   // last_event
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bgd_pkg::cfg_type   cfg_ff;
   bgd_pkg::evgrp_type core_grp;
   bgd_pkg::evt_type   rsp_code;
   logic               grp_load;
   logic               load_ok;

   // Register file; the user must write only while the block is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms   <= bgd_pkg::LONG_PRESS_RESET;
         cfg_ff.click_window_ms <= bgd_pkg::CLICK_WINDOW_RESET;
         cfg_ff.debounce_ms     <= bgd_pkg::DEBOUNCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bgd_pkg::CSR_LONG_PRESS:   cfg_ff.long_press_ms   <= csr_wdata;
            bgd_pkg::CSR_CLICK_WINDOW: cfg_ff.click_window_ms <= csr_wdata;
            bgd_pkg::CSR_DEBOUNCE:     cfg_ff.debounce_ms     <= csr_wdata[7:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // Tick evaluation: window expiry, long press expiry, then debounced edge.
   bgd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_pin    (req_tdata[0]),
      .load_ok    (load_ok),
      .grp_load   (grp_load),
      .grp        (core_grp)
   );

   // Serializes each tick's events onto the response channel.
   bgd_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .grp_load   (grp_load),
      .grp        (core_grp),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_code   (rsp_code),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, rsp_code};

   // A group handed to the queue always carries at least one event.
   a_grp_nonempty: assert property (@(posedge clock) disable iff (reset)
      grp_load |-> (core_grp.count != 2'd0))
      else $error("empty event group loaded");

   // The core loads only when the queue can take the group.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      grp_load |-> load_ok)
      else $error("event group loaded over a pending group");

   // After a transfer that is not the last of a tick, more events follow.
   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("event group ended without tlast");

endmodule

### sv/bgd_core.sv
// bgd_core: input register, gesture state and the per-tick update logic.
// Depends on bgd_pkg; hands event groups to bgd_evq.
`timescale 1ns / 1ps

module bgd_core (
   input  logic                clock,
   input  logic                reset,
   input  bgd_pkg::cfg_type    cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_pin,
   input  logic                load_ok,
   output logic                grp_load,
   output bgd_pkg::evgrp_type  grp
);

   localparam int TW = bgd_pkg::TIME_WIDTH;
   localparam logic [TW-1:0] TIME_ONE_C = bgd_pkg::TIME_ONE;

   logic          in_valid_ff;
   logic          in_pin_ff;

   logic          stable_pressed_ff, stable_pressed_in;
   logic [7:0]    settle_count_ff, settle_count_in;
   logic          settle_active_ff, settle_active_in;
   logic [TW-1:0] hold_count_ff, hold_count_in;
   logic          hold_active_ff, hold_active_in;
   logic          long_fired_ff, long_fired_in;
   logic [TW-1:0] window_count_ff, window_count_in;
   logic          window_active_ff, window_active_in;
   logic [1:0]    clicks_seen_ff, clicks_seen_in;

   bgd_pkg::evt_type ev [3];
   logic [1:0]       n;
   logic             fire;

   always_comb begin
      logic pressed;
      logic edge_take;
      pressed           = ~in_pin_ff;
      edge_take         = 1'b0;
      n                 = 2'd0;
      ev[0]             = bgd_pkg::EV_PRESSED;
      ev[1]             = bgd_pkg::EV_PRESSED;
      ev[2]             = bgd_pkg::EV_PRESSED;
      stable_pressed_in = stable_pressed_ff;
      settle_count_in   = settle_count_ff;
      settle_active_in  = settle_active_ff;
      hold_count_in     = hold_count_ff;
      hold_active_in    = hold_active_ff;
      long_fired_in     = long_fired_ff;
      window_count_in   = window_count_ff;
      window_active_in  = window_active_ff;
      clicks_seen_in    = clicks_seen_ff;

      // click window expiry
      if (window_active_ff) begin
         if (window_count_ff <= TIME_ONE_C) begin
            window_count_in  = '0;
            window_active_in = 1'b0;
            if (clicks_seen_ff == 2'd2) begin
               ev[n] = bgd_pkg::EV_DOUBLE;
               n     = n + 2'd1;
            end else if (clicks_seen_ff == 2'd1) begin
               ev[n] = bgd_pkg::EV_CLICK;
               n     = n + 2'd1;
            end
            clicks_seen_in = 2'd0;
         end else begin
            window_count_in = window_count_ff - TIME_ONE_C;
         end
      end

      // long press expiry
      if (hold_active_ff) begin
         if (hold_count_ff <= TIME_ONE_C) begin
            hold_count_in  = '0;
            hold_active_in = 1'b0;
            long_fired_in  = 1'b1;
            if (n != 2'd3) begin
               ev[n] = bgd_pkg::EV_LONG;
               n     = n + 2'd1;
            end
         end else begin
            hold_count_in = hold_count_ff - TIME_ONE_C;
         end
      end

      // debounce
      if (settle_active_ff) begin
         if (settle_count_ff != 8'd0) begin
            settle_count_in = settle_count_ff - 8'd1;
         end
         if (settle_count_in == 8'd0) begin
            settle_active_in = 1'b0;
            edge_take        = 1'b1;
         end
      end else if (pressed != stable_pressed_ff) begin
         settle_count_in = cfg.debounce_ms;
         if (cfg.debounce_ms == 8'd0) begin
            edge_take = 1'b1;
         end else begin
            settle_active_in = 1'b1;
         end
      end

      // debounced edge
      if (edge_take && (pressed != stable_pressed_ff)) begin
         stable_pressed_in = pressed;
         if (pressed) begin
            hold_active_in = 1'b1;
            hold_count_in  = bgd_pkg::to_time(cfg.long_press_ms);
            long_fired_in  = 1'b0;
            if (n != 2'd3) begin
               ev[n] = bgd_pkg::EV_PRESSED;
               n     = n + 2'd1;
            end
         end else begin
            hold_active_in = 1'b0;
            if (!long_fired_in) begin
               clicks_seen_in = clicks_seen_in + 2'd1;
               if (clicks_seen_in == 2'd1) begin
                  window_active_in = 1'b1;
                  window_count_in  = bgd_pkg::to_time(cfg.click_window_ms);
               end else if (clicks_seen_in == 2'd3) begin
                  window_active_in = 1'b0;
                  clicks_seen_in   = 2'd0;
                  if (n != 2'd3) begin
                     ev[n] = bgd_pkg::EV_TRIPLE;
                     n     = n + 2'd1;
                  end
               end
            end
            if (n != 2'd3) begin
               ev[n] = bgd_pkg::EV_RELEASED;
               n     = n + 2'd1;
            end
         end
      end
   end

   // A tick with no events never waits for the event queue.
   assign fire       = in_valid_ff && ((n == 2'd0) || load_ok);
   assign req_tready = !in_valid_ff || fire;
   assign grp_load   = fire && (n != 2'd0);
   assign grp.count  = n;
   assign grp.code0  = ev[0];
   assign grp.code1  = ev[1];
   assign grp.code2  = ev[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         stable_pressed_ff <= 1'b0;
         settle_count_ff   <= '0;
         settle_active_ff  <= 1'b0;
         hold_count_ff     <= '0;
         hold_active_ff    <= 1'b0;
         long_fired_ff     <= 1'b0;
         window_count_ff   <= '0;
         window_active_ff  <= 1'b0;
         clicks_seen_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            stable_pressed_ff <= stable_pressed_in;
            settle_count_ff   <= settle_count_in;
            settle_active_ff  <= settle_active_in;
            hold_count_ff     <= hold_count_in;
            hold_active_ff    <= hold_active_in;
            long_fired_ff     <= long_fired_in;
            window_count_ff   <= window_count_in;
            window_active_ff  <= window_active_in;
            clicks_seen_ff    <= clicks_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_pin_ff <= req_pin;
      end
   end

endmodule

### sv/bgd_evq.sv
// bgd_evq: event group register that sends one event per response transfer.
// Depends on bgd_pkg; fed by bgd_core.
`timescale 1ns / 1ps

module bgd_evq (
   input  logic                clock,
   input  logic                reset,
   input  logic                grp_load,
   input  bgd_pkg::evgrp_type  grp,
   output logic                load_ok,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output bgd_pkg::evt_type    rsp_code,
   output logic                rsp_last
);

   bgd_pkg::evgrp_type grp_ff;
   logic               valid_ff;
   logic [1:0]         idx_ff;
   logic               pop;

   always_comb begin
      unique case (idx_ff)
         2'd0:    rsp_code = grp_ff.code0;
         2'd1:    rsp_code = grp_ff.code1;
         default: rsp_code = grp_ff.code2;
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_last   = (idx_ff == (grp_ff.count - 2'd1));
   assign pop        = valid_ff && rsp_tready;
   // Free in the same cycle that the last event of the group is taken.
   assign load_ok    = !valid_ff || (pop && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (grp_load) begin
            valid_ff <= 1'b1;
            idx_ff   <= '0;
         end else if (pop) begin
            if (rsp_last) begin
               valid_ff <= 1'b0;
               idx_ff   <= '0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grp_load) begin
         grp_ff <= grp;
      end
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for button_gesture_detector_top (debounce, press, long press, clicks).
// Depends on bgd_pkg and the top level; predicts events with its own gesture model.

module tb;

   // Marks a tick whose events come from the predictor, not from the plan.
   localparam int USE_MODEL      = -1;
   // Ticks that cause no event may still sit in the two-stage pipe.
   localparam int QUIET_CYCLES   = 8;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int END_WAIT       = 20000;
   localparam int RUN_LIMIT      = 50000;
   // Filler for unused event slots of a plan row.
   localparam bgd_pkg::evt_type FILL = bgd_pkg::EV_PRESSED;

   typedef enum logic {ROW_CFG, ROW_TICK} row_kind_type;

   // One line of the directed plan: a register write or a run of ticks.
   typedef struct {
      row_kind_type     kind;
      logic [1:0]       idx;
      logic [15:0]      value;
      logic             pin;
      int               reps;
      int               typed_n;
      bgd_pkg::evt_type ev0;
      bgd_pkg::evt_type ev1;
      bgd_pkg::evt_type ev2;
   } plan_row_type;

   typedef struct packed {
      bgd_pkg::evt_type code;
      logic             last;
   } evt_rec_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [0] pin_level, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [2:0] event_code, [7:3] zero
   logic        rsp_tlast;   // last_event
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   button_gesture_detector_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns period, high then low.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Gesture predictor: its own copy of registers and state.
   // ---------------------------------------------------------------
   logic [15:0]                    cfg_long;
   logic [15:0]                    cfg_window;
   logic [7:0]                     cfg_debounce;

   logic                           st_pressed;
   logic [7:0]                     st_settle;
   logic                           st_settling;
   logic [bgd_pkg::TIME_WIDTH-1:0] st_hold;
   logic                           st_holding;
   logic                           st_long_fired;
   logic [bgd_pkg::TIME_WIDTH-1:0] st_window;
   logic                           st_window_open;
   logic [1:0]                     st_clicks;

   // Events of the tick just predicted, in emission order.
   bgd_pkg::evt_type tick_ev [0:2];
   int               tick_cnt;

   task add_event(input bgd_pkg::evt_type code);
      if (tick_cnt < 3) begin
         tick_ev[tick_cnt] = code;
         tick_cnt++;
      end
   endtask

   // A debounced level that differs from the held one is a press or release.
   task take_edge(input logic now_pressed);
      if (now_pressed != st_pressed) begin
         st_pressed = now_pressed;
         if (now_pressed) begin
            st_holding    = 1'b1;
            st_hold       = bgd_pkg::TIME_WIDTH'(cfg_long);
            st_long_fired = 1'b0;
            add_event(bgd_pkg::EV_PRESSED);
         end else begin
            st_holding = 1'b0;
            // a release after a long press is not a click
            if (!st_long_fired) begin
               st_clicks = st_clicks + 2'd1;
               if (st_clicks == 2'd1) begin
                  st_window_open = 1'b1;
                  st_window      = bgd_pkg::TIME_WIDTH'(cfg_window);
               end else if (st_clicks == 2'd3) begin
                  st_window_open = 1'b0;
                  st_clicks      = 2'd0;
                  add_event(bgd_pkg::EV_TRIPLE);
               end
            end
            add_event(bgd_pkg::EV_RELEASED);
         end
      end
   endtask

   // Window expiry first, then long-press expiry, then the debounced edge.
   task predict_tick(input logic pin);
      logic pressed;
      pressed  = !pin;
      tick_cnt = 0;

      if (st_window_open) begin
         if (st_window <= 1) begin
            st_window      = '0;
            st_window_open = 1'b0;
            if (st_clicks == 2'd2) begin
               add_event(bgd_pkg::EV_DOUBLE);
            end else if (st_clicks == 2'd1) begin
               add_event(bgd_pkg::EV_CLICK);
            end
            st_clicks = 2'd0;
         end else begin
            st_window = st_window - 1'b1;
         end
      end

      if (st_holding) begin
         if (st_hold <= 1) begin
            st_hold       = '0;
            st_holding    = 1'b0;
            st_long_fired = 1'b1;
            add_event(bgd_pkg::EV_LONG);
         end else begin
            st_hold = st_hold - 1'b1;
         end
      end

      // level changes while settling are ignored; only the final sample counts
      if (st_settling) begin
         if (st_settle != 8'd0) begin
            st_settle = st_settle - 8'd1;
         end
         if (st_settle == 8'd0) begin
            st_settling = 1'b0;
            take_edge(pressed);
         end
      end else if (pressed != st_pressed) begin
         st_settle = cfg_debounce;
         if (st_settle == 8'd0) begin
            take_edge(pressed);   // zero debounce: sampled in the same tick
         end else begin
            st_settling = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Scoreboard: expected events in order, checked on each rsp transfer.
   // ---------------------------------------------------------------
   evt_rec_type pending_events [$];
   int          fail_count;
   int          ticks_sent;
   int          cycle_count;

   // Events typed into the plan for the tick currently offered.
   int               offer_typed;
   bgd_pkg::evt_type offer_ev [0:2];

   always @(posedge clock) begin : monitor
      evt_rec_type want;
      evt_rec_type rec;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               $error("unexpected event transfer: event_code %0d last_event %0b",
                      rsp_tdata[2:0], rsp_tlast);
               fail_count++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_tdata[2:0] !== want.code) begin
                  $error("event_code: expected %0d, got %0d", want.code, rsp_tdata[2:0]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_event: expected %0b, got %0b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         // the predictor always advances; typed rows override its events
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[0]);
            if (offer_typed != USE_MODEL) begin
               tick_cnt = offer_typed;
               tick_ev  = offer_ev;
            end
            for (int k = 0; k < tick_cnt; k++) begin
               rec.code = tick_ev[k];
               rec.last = (k == tick_cnt - 1);
               pending_events.push_back(rec);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off counted here.
   // ---------------------------------------------------------------
   int   rsp_stall_pct;
   int   req_idle_pct;
   logic holdoff_start;
   int   holdoff_left;

   always @(negedge clock) begin
      if (holdoff_start) begin
         holdoff_left  = HOLDOFF_CYCLES;
         holdoff_start = 1'b0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Sender side. Every task starts and ends at a falling edge.
   // ---------------------------------------------------------------
   task send_tick(input logic pin, input int typed_n, input bgd_pkg::evt_type e0,
                  input bgd_pkg::evt_type e1, input bgd_pkg::evt_type e2);
      // one assignment to req_tvalid per step, even across back-to-back calls
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= {7'b0, pin};
      offer_typed = typed_n;
      offer_ev[0] = e0;
      offer_ev[1] = e1;
      offer_ev[2] = e2;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   task send_level(input logic pin, input int n);
      repeat (n) send_tick(pin, USE_MODEL, FILL, FILL, FILL);
   endtask

   // Stop offering and let every expected transfer land before a write.
   task wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         bgd_pkg::CSR_LONG_PRESS:   cfg_long     = val;
         bgd_pkg::CSR_CLICK_WINDOW: cfg_window   = val;
         bgd_pkg::CSR_DEBOUNCE:     cfg_debounce = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task apply_setting(input int l, input int w, input int d);
      wait_quiet();
      csr_write(bgd_pkg::CSR_LONG_PRESS, l[15:0]);
      csr_write(bgd_pkg::CSR_CLICK_WINDOW, w[15:0]);
      csr_write(bgd_pkg::CSR_DEBOUNCE, {8'b0, d[7:0]});
   endtask

   // Mostly well-formed press/release pairs with random lengths near the
   // timer limits; some get contact bounce, some are pure noise.
   task run_gesture();
      int cap_l;
      int cap_w;
      int press_len;
      int gap_len;
      if ($urandom_range(4, 0) == 0) begin
         repeat ($urandom_range(8, 1)) send_level(1'($urandom_range(1, 0)), 1);
      end else begin
         cap_l = (cfg_long > 37) ? 40 : int'(cfg_long) + 3;
         cap_w = (cfg_window > 37) ? 40 : int'(cfg_window) + 3;
         if ($urandom_range(2, 0) == 0) begin
            repeat ($urandom_range(3, 1)) begin
               send_level(1'b0, 1);
               send_level(1'b1, 1);
            end
         end
         press_len = ($urandom_range(1, 0) == 1) ? $urandom_range(3, 1)
                                                 : $urandom_range(cap_l, 1);
         send_level(1'b0, int'(cfg_debounce) + press_len);
         gap_len = ($urandom_range(1, 0) == 1) ? $urandom_range(3, 1)
                                               : $urandom_range(cap_w, 1);
         send_level(1'b1, int'(cfg_debounce) + gap_len);
      end
   endtask

   // Directed plan builders.
   plan_row_type plan [$];

   task add_tick(input logic pin, input int reps, input int typed_n,
                 input bgd_pkg::evt_type e0, input bgd_pkg::evt_type e1,
                 input bgd_pkg::evt_type e2);
      plan_row_type row;
      row.kind    = ROW_TICK;
      row.idx     = '0;
      row.value   = '0;
      row.pin     = pin;
      row.reps    = reps;
      row.typed_n = typed_n;
      row.ev0     = e0;
      row.ev1     = e1;
      row.ev2     = e2;
      plan.push_back(row);
   endtask

   task add_cfg(input logic [1:0] idx, input logic [15:0] value);
      plan_row_type row;
      row.kind    = ROW_CFG;
      row.idx     = idx;
      row.value   = value;
      row.pin     = 1'b1;
      row.reps    = 0;
      row.typed_n = 0;
      row.ev0     = FILL;
      row.ev1     = FILL;
      row.ev2     = FILL;
      plan.push_back(row);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : main
      int l;
      int w;
      int d;
      int start_ticks;
      int waited;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      holdoff_start = 1'b0;
      holdoff_left  = 0;
      rsp_stall_pct = 0;
      req_idle_pct  = 0;
      fail_count    = 0;
      ticks_sent    = 0;
      cycle_count   = 0;
      offer_typed   = USE_MODEL;
      offer_ev[0]   = FILL;
      offer_ev[1]   = FILL;
      offer_ev[2]   = FILL;

      // predictor in its reset state
      cfg_long       = bgd_pkg::LONG_PRESS_RESET;
      cfg_window     = bgd_pkg::CLICK_WINDOW_RESET;
      cfg_debounce   = bgd_pkg::DEBOUNCE_RESET;
      st_pressed     = 1'b0;
      st_settle      = '0;
      st_settling    = 1'b0;
      st_hold        = '0;
      st_holding     = 1'b0;
      st_long_fired  = 1'b0;
      st_window      = '0;
      st_window_open = 1'b0;
      st_clicks      = 2'd0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed plan: no debounce, long press 5, click window 6 so that
      // long press and window expiry can land on the same tick.
      add_tick(1'b1, 1, 0, FILL, FILL, FILL);       // idle after reset
      add_cfg(bgd_pkg::CSR_DEBOUNCE, 16'd0);
      add_cfg(bgd_pkg::CSR_LONG_PRESS, 16'd5);
      add_cfg(bgd_pkg::CSR_CLICK_WINDOW, 16'd6);
      // press held into a long press, then a release that is no click
      add_tick(1'b0, 1, 1, bgd_pkg::EV_PRESSED, FILL, FILL);
      add_tick(1'b0, 4, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b0, 1, 1, bgd_pkg::EV_LONG, FILL, FILL);
      add_tick(1'b1, 1, 1, bgd_pkg::EV_RELEASED, FILL, FILL);
      // one click, then a long press whose release meets the window expiry:
      // three events from one tick
      add_tick(1'b0, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b1, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b0, 5, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b1, 1, 3, bgd_pkg::EV_CLICK, bgd_pkg::EV_LONG, bgd_pkg::EV_RELEASED);
      // double click, closed by window expiry
      add_tick(1'b0, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b1, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b0, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b1, 5, USE_MODEL, FILL, FILL, FILL);
      // triple click: TRIPLE comes ahead of RELEASED
      add_tick(1'b0, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b1, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b0, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b1, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b0, 1, USE_MODEL, FILL, FILL, FILL);
      add_tick(1'b1, 1, 2, bgd_pkg::EV_TRIPLE, bgd_pkg::EV_RELEASED, FILL);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            wait_quiet();
            csr_write(plan[i].idx, plan[i].value);
         end else begin
            repeat (plan[i].reps) begin
               send_tick(plan[i].pin, plan[i].typed_n,
                         plan[i].ev0, plan[i].ev1, plan[i].ev2);
            end
         end
      end

      // Random part: one setting per round, idle pattern rotating with it.
      // Zero timers act like one; the max-timer round keeps a short debounce
      // so that its gestures stay short.
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: begin l = 0; w = 0; d = 0; end
            1: begin l = 1; w = 1; d = 1; end
            2: begin l = 65535; w = 65535; d = 2; end
            default: begin
               l = $urandom_range(12, 2);
               w = $urandom_range(14, 2);
               d = $urandom_range(3, 0);
            end
         endcase
         apply_setting(l, w, d);
         case (s % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 85; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 85; end
            default: begin req_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         start_ticks = ticks_sent;
         while (ticks_sent - start_ticks < 15) begin
            run_gesture();
         end
      end

      // Back-pressure: receiver holds off while every tick toggles the level,
      // so the event register fills and the tick channel stalls.
      apply_setting(5, 6, 0);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      holdoff_start = 1'b1;
      for (int k = 0; k < 24; k++) begin
         send_level(k[0], 1);
      end

      // Drain, with a bound, then let the pipe empty out.
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_events.size() != 0 && waited < END_WAIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(negedge clock);
      if (pending_events.size() != 0) begin
         $error("%0d expected event transfers never arrived", pending_events.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
